### design/vertex_normal_transform_top_defines.svh
// assertion macros for the vertex and normal transform
// used by vertex_normal_transform_top, needs clk and rst_n in scope
`ifndef VERTEX_NORMAL_TRANSFORM_TOP_DEFINES_SVH
`define VERTEX_NORMAL_TRANSFORM_TOP_DEFINES_SVH

`define VNT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vnt check failed");

`define VNT_ASSERT_DLY(lbl, ante, n, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##(n) (cons)) \
    else $error("vnt latency check failed");

`endif

### design/vnt_pkg.sv
// shared types and constants for the vertex and normal transform
// no dependencies
package vnt_pkg;

  typedef enum logic [2:0] {
    REG_ROW_X  = 3'd0,
    REG_ROW_Y  = 3'd1,
    REG_ROW_Z  = 3'd2,
    REG_ROW_W  = 3'd3,
    REG_NROW_X = 3'd4,
    REG_NROW_Y = 3'd5,
    REG_NROW_Z = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [3:0][63:0] prow;
    logic [2:0][47:0] nrow;
  } cfg_t;

  localparam logic [63:0] RST_ROW_X  = 64'd4096;
  localparam logic [63:0] RST_ROW_Y  = 64'd4096 << 16;
  localparam logic [63:0] RST_ROW_Z  = 64'd4096 << 32;
  localparam logic [63:0] RST_ROW_W  = 64'd256 << 48;
  localparam logic [47:0] RST_NROW_X = 48'd4096;
  localparam logic [47:0] RST_NROW_Y = 48'd4096 << 16;
  localparam logic [47:0] RST_NROW_Z = 48'd4096 << 32;

  // normal sums: three 16x16 products
  localparam int NSUM_W = 34;
  localparam int NMAG_W = 33;
  localparam int NM_W   = 30;
  localparam int NORM_TOP = 29;
  localparam int SQRT_STEPS = 32;
  localparam int NDIV_STEPS = 16;
  // normal unit stage count from sums to result register
  localparam int NRM_LAT = 5 + SQRT_STEPS + 1 + NDIV_STEPS + 1;
  localparam int FRONT_LAT = 2;

endpackage

### design/vnt_front.sv
// product and dot-product stages for position and normal rows
// depends on vnt_pkg
module vnt_front #(
  parameter int PW = 24
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_vld,
  input  logic                                in_cmd,
  input  logic signed [PW-1:0]                pos [3],
  input  logic signed [15:0]                  nrm [3],
  input  vnt_pkg::cfg_t                       cfg,
  output logic                                o_vld,
  output logic                                o_cmd,
  output logic signed [PW+17:0]               num [4],
  output logic signed [vnt_pkg::NSUM_W-1:0]   nsum [3]
);
  localparam int NW  = PW + 18;
  localparam int PRW = PW + 16;

  logic signed [PRW-1:0] pprod_r [4][3];
  logic signed [31:0]    trans_r [4];
  logic signed [31:0]    nprod_r [3][3];
  logic                  vld1_r, cmd1_r, vld2_r, cmd2_r;
  logic signed [NW-1:0]  num_r [4];
  logic signed [vnt_pkg::NSUM_W-1:0] nsum_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else begin
      vld1_r <= in_vld;
      vld2_r <= vld1_r;
    end
    cmd1_r <= in_cmd;
    cmd2_r <= cmd1_r;
    for (int i = 0; i < 4; i++) begin
      for (int k = 0; k < 3; k++) begin
        pprod_r[i][k] <= $signed(cfg.prow[i][16*k +: 16]) * pos[k];
      end
      trans_r[i] <= $signed({cfg.prow[i][63:48], 16'h0000});
      num_r[i] <= NW'(pprod_r[i][0]) + NW'(pprod_r[i][1]) + NW'(pprod_r[i][2])
                  + NW'(trans_r[i]);
    end
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        nprod_r[i][k] <= $signed(cfg.nrow[i][16*k +: 16]) * nrm[k];
      end
      nsum_r[i] <= vnt_pkg::NSUM_W'(nprod_r[i][0]) + vnt_pkg::NSUM_W'(nprod_r[i][1])
                   + vnt_pkg::NSUM_W'(nprod_r[i][2]);
    end
  end

  assign o_vld = vld2_r;
  assign o_cmd = cmd2_r;
  assign num   = num_r;
  assign nsum  = nsum_r;

endmodule

### design/vnt_pos_div.sv
// position path: magnitudes, pipelined restoring divide by w, saturation
// no dependencies
module vnt_pos_div #(
  parameter int PW = 24
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_vld,
  input  logic                 in_cmd,
  input  logic signed [PW+17:0] num [4],
  output logic [PW-1:0]        o_pos [3],
  output logic                 o_wz
);
  localparam int NW = PW + 18;
  localparam int DW = NW + 12;
  localparam int QB = PW + 1;
  localparam logic [QB-1:0] QMAX = {2'b00, {(PW-1){1'b1}}};
  localparam logic [QB-1:0] QLIM = {2'b01, {(PW-1){1'b0}}};
  localparam logic [PW-1:0] PMAX = {1'b0, {(PW-1){1'b1}}};
  localparam logic [PW-1:0] PMIN = {1'b1, {(PW-1){1'b0}}};

  typedef struct packed {
    logic       cmd;
    logic       wz;
    logic [2:0] ovf;
    logic [2:0] qneg;
    logic [2:0] nneg;
    logic [2:0] nz;
  } pflag_t;

  logic          vld_a_r, cmd_a_r;
  logic [NW-1:0] mag_a_r [4];
  logic          neg_a_r [4];

  logic          vld_r [QB+1];
  logic [NW-1:0] rem_r [QB+1][3];
  logic [QB-1:0] sh_r  [QB+1][3];
  logic [NW-1:0] d_r   [QB+1];
  pflag_t        fl_r  [QB+1];

  logic [DW-1:0] dd_c [3];
  logic [NW-1:0] r0_c [3];
  pflag_t        fl0_c;

  logic [QB-1:0] nq_c  [3];
  logic [PW-1:0] res_c [3];
  logic [PW-1:0] pos_r [3];
  logic          wz_r;

  // magnitudes and signs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
    end else begin
      vld_a_r <= in_vld;
    end
    cmd_a_r <= in_cmd;
    for (int i = 0; i < 4; i++) begin
      neg_a_r[i] <= num[i][NW-1];
      mag_a_r[i] <= num[i][NW-1] ? NW'(-num[i]) : NW'(num[i]);
    end
  end

  // first partial remainder and overflow check
  always_comb begin
    fl0_c.cmd = cmd_a_r;
    fl0_c.wz  = (mag_a_r[3] == '0);
    for (int i = 0; i < 3; i++) begin
      dd_c[i] = {mag_a_r[i], 12'h000};
      r0_c[i] = NW'(dd_c[i][DW-1:QB]);
      fl0_c.ovf[i]  = (r0_c[i] >= mag_a_r[3]);
      fl0_c.qneg[i] = neg_a_r[i] ^ neg_a_r[3];
      fl0_c.nneg[i] = neg_a_r[i];
      fl0_c.nz[i]   = (mag_a_r[i] != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= vld_a_r;
    end
    d_r[0]  <= mag_a_r[3];
    fl_r[0] <= fl0_c;
    for (int i = 0; i < 3; i++) begin
      rem_r[0][i] <= r0_c[i];
      sh_r[0][i]  <= dd_c[i][QB-1:0];
    end
  end

  // one quotient bit per stage
  for (genvar k = 0; k < QB; k++) begin : g_div
    logic [NW:0] t [3];
    logic        ge [3];

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        t[i]  = {rem_r[k][i], sh_r[k][i][QB-1]};
        ge[i] = (t[i] >= {1'b0, d_r[k]});
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else begin
        vld_r[k+1] <= vld_r[k];
      end
      d_r[k+1]  <= d_r[k];
      fl_r[k+1] <= fl_r[k];
      for (int i = 0; i < 3; i++) begin
        rem_r[k+1][i] <= ge[i] ? NW'(t[i] - {1'b0, d_r[k]}) : NW'(t[i]);
        sh_r[k+1][i]  <= {sh_r[k][i][QB-2:0], ge[i]};
      end
    end
  end

  // sign, saturation and special cases
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nq_c[i] = QB'(0) - sh_r[QB][i];
      if (fl_r[QB].cmd) begin
        res_c[i] = '0;
      end else if (fl_r[QB].wz) begin
        res_c[i] = !fl_r[QB].nz[i] ? '0 : (fl_r[QB].nneg[i] ? PMIN : PMAX);
      end else if (fl_r[QB].qneg[i]) begin
        res_c[i] = (fl_r[QB].ovf[i] || sh_r[QB][i] > QLIM) ? PMIN : nq_c[i][PW-1:0];
      end else begin
        res_c[i] = (fl_r[QB].ovf[i] || sh_r[QB][i] > QMAX) ? PMAX : sh_r[QB][i][PW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    pos_r <= res_c;
    wz_r  <= fl_r[QB].wz & ~fl_r[QB].cmd;
  end

  assign o_pos = pos_r;
  assign o_wz  = wz_r;

endmodule

### design/vnt_nrm_unit.sv
// normal path: magnitude scaling, sum of squares, pipelined square root
// and pipelined rounding divide; depends on vnt_pkg
module vnt_nrm_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_vld,
  input  logic signed [vnt_pkg::NSUM_W-1:0] nsum [3],
  output logic                              o_vld,
  output logic [15:0]                       o_nrm [3],
  output logic                              o_zero
);
  localparam int MW = vnt_pkg::NMAG_W;
  localparam int SW = vnt_pkg::NM_W;
  localparam int SS = vnt_pkg::SQRT_STEPS;
  localparam int DS = vnt_pkg::NDIV_STEPS;

  typedef struct packed {
    logic [2:0][SW-1:0] m;
    logic [2:0]         neg;
    logic               zero;
  } ncar_t;

  logic          vld_a_r, vld_b_r, vld_c_r, vld_d_r;
  logic [MW-1:0] mag_a_r [3];
  logic [2:0]    neg_a_r, neg_b_r;
  logic [MW-1:0] mag_b_r [3];
  logic [5:0]    p_b_r;
  logic          zero_b_r;
  logic [MW-1:0] mx_c;
  logic [5:0]    p_c;
  ncar_t         car_c_r, car_d_r;
  logic [MW+SW-1:0] lsh_c [3];
  logic [MW-1:0]    rsh_c [3];
  ncar_t         shc_c;
  logic [2*SW-1:0] sq_d_r [3];

  logic          vs_r   [SS+1];
  logic [63:0]   v_r    [SS+1];
  logic [63:0]   res_r  [SS+1];
  ncar_t         car_s_r [SS+1];

  logic          vq_r   [DS+1];
  logic [31:0]   rem_r  [DS+1][3];
  logic [15:0]   sh_r   [DS+1][3];
  logic [31:0]   d_r    [DS+1];
  logic [2:0]    qneg_r [DS+1];
  logic          qz_r   [DS+1];
  logic [44:0]   n_c    [3];

  logic [15:0]   qc_c   [3];
  logic [15:0]   out_c  [3];
  logic          vo_r, zo_r;
  logic [15:0]   nrm_r  [3];

  // magnitudes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
    end else begin
      vld_a_r <= in_vld;
    end
    for (int i = 0; i < 3; i++) begin
      neg_a_r[i] <= nsum[i][vnt_pkg::NSUM_W-1];
      mag_a_r[i] <= nsum[i][vnt_pkg::NSUM_W-1] ? MW'(-nsum[i]) : MW'(nsum[i]);
    end
  end

  // largest magnitude and its leading one
  always_comb begin
    mx_c = mag_a_r[0];
    if (mag_a_r[1] > mx_c) begin
      mx_c = mag_a_r[1];
    end
    if (mag_a_r[2] > mx_c) begin
      mx_c = mag_a_r[2];
    end
    p_c = '0;
    for (int b = 0; b < MW; b++) begin
      if (mx_c[b]) begin
        p_c = 6'(b);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_b_r <= 1'b0;
    end else begin
      vld_b_r <= vld_a_r;
    end
    mag_b_r  <= mag_a_r;
    neg_b_r  <= neg_a_r;
    p_b_r    <= p_c;
    zero_b_r <= (mx_c == '0);
  end

  // common scaling so the largest lies in [2^29, 2^30)
  always_comb begin
    shc_c.neg  = neg_b_r;
    shc_c.zero = zero_b_r;
    for (int i = 0; i < 3; i++) begin
      lsh_c[i] = {{SW{1'b0}}, mag_b_r[i]} << (6'(vnt_pkg::NORM_TOP) - p_b_r);
      rsh_c[i] = mag_b_r[i] >> (p_b_r - 6'(vnt_pkg::NORM_TOP));
      if (p_b_r < 6'(vnt_pkg::NORM_TOP)) begin
        shc_c.m[i] = lsh_c[i][SW-1:0];
      end else begin
        shc_c.m[i] = rsh_c[i][SW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_c_r <= 1'b0;
      vld_d_r <= 1'b0;
    end else begin
      vld_c_r <= vld_b_r;
      vld_d_r <= vld_c_r;
    end
    car_c_r <= shc_c;
    car_d_r <= car_c_r;
    for (int i = 0; i < 3; i++) begin
      sq_d_r[i] <= car_c_r.m[i] * car_c_r.m[i];
    end
  end

  // sum of squares feeds the root
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vs_r[0] <= 1'b0;
    end else begin
      vs_r[0] <= vld_d_r;
    end
    v_r[0]     <= 64'(sq_d_r[0]) + 64'(sq_d_r[1]) + 64'(sq_d_r[2]);
    res_r[0]   <= '0;
    car_s_r[0] <= car_d_r;
  end

  for (genvar k = 0; k < SS; k++) begin : g_sqrt
    localparam logic [63:0] BITV = 64'd1 << (62 - 2 * k);
    logic [63:0] rb, vn, rn;

    always_comb begin
      rb = res_r[k] + BITV;
      if (v_r[k] >= rb) begin
        vn = v_r[k] - rb;
        rn = (res_r[k] >> 1) + BITV;
      end else begin
        vn = v_r[k];
        rn = res_r[k] >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vs_r[k+1] <= 1'b0;
      end else begin
        vs_r[k+1] <= vs_r[k];
      end
      v_r[k+1]     <= vn;
      res_r[k+1]   <= rn;
      car_s_r[k+1] <= car_s_r[k];
    end
  end

  // rounded dividend m * 2^14 + r / 2
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      n_c[i] = {1'b0, car_s_r[SS].m[i], 14'h0000} + 45'(res_r[SS][31:1]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vq_r[0] <= 1'b0;
    end else begin
      vq_r[0] <= vs_r[SS];
    end
    d_r[0]    <= res_r[SS][31:0];
    qneg_r[0] <= car_s_r[SS].neg;
    qz_r[0]   <= car_s_r[SS].zero;
    for (int i = 0; i < 3; i++) begin
      rem_r[0][i] <= 32'(n_c[i][44:16]);
      sh_r[0][i]  <= n_c[i][15:0];
    end
  end

  for (genvar k = 0; k < DS; k++) begin : g_div
    logic [32:0] t [3];
    logic        ge [3];

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        t[i]  = {rem_r[k][i], sh_r[k][i][15]};
        ge[i] = (t[i] >= {1'b0, d_r[k]});
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vq_r[k+1] <= 1'b0;
      end else begin
        vq_r[k+1] <= vq_r[k];
      end
      d_r[k+1]    <= d_r[k];
      qneg_r[k+1] <= qneg_r[k];
      qz_r[k+1]   <= qz_r[k];
      for (int i = 0; i < 3; i++) begin
        rem_r[k+1][i] <= ge[i] ? 32'(t[i] - {1'b0, d_r[k]}) : 32'(t[i]);
        sh_r[k+1][i]  <= {sh_r[k][i][14:0], ge[i]};
      end
    end
  end

  // clamp, sign, zero length
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qc_c[i] = (sh_r[DS][i] > 16'd32767) ? 16'd32767 : sh_r[DS][i];
      if (qz_r[DS]) begin
        out_c[i] = '0;
      end else if (qneg_r[DS][i]) begin
        out_c[i] = 16'd0 - qc_c[i];
      end else begin
        out_c[i] = qc_c[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else begin
      vo_r <= vq_r[DS];
    end
    zo_r  <= qz_r[DS];
    nrm_r <= out_c;
  end

  assign o_vld  = vo_r;
  assign o_zero = zo_r;
  assign o_nrm  = nrm_r;

endmodule

### design/vertex_normal_transform_top.sv
// vertex and face normal transform, pipelined from the accepting edge to out_valid:
// one item accepted every cycle while busy is low, results cannot be held off
// the 32-stage square root and 16-stage normal divide make the normal path the longer one
// reset clears all valid bits and loads the identity into every row register
// depends on vnt_pkg, vnt_front, vnt_pos_div, vnt_nrm_unit and the defines header
`include "vertex_normal_transform_top_defines.svh"
module vertex_normal_transform_top #(
  parameter int POSITION_WIDTH = 24
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic                             in_command,
  input  logic signed [POSITION_WIDTH-1:0] in_pos_x,
  input  logic signed [POSITION_WIDTH-1:0] in_pos_y,
  input  logic signed [POSITION_WIDTH-1:0] in_pos_z,
  input  logic signed [15:0]               in_nrm_x,
  input  logic signed [15:0]               in_nrm_y,
  input  logic signed [15:0]               in_nrm_z,
  output logic                             out_valid,
  output logic signed [POSITION_WIDTH-1:0] out_pos_x,
  output logic signed [POSITION_WIDTH-1:0] out_pos_y,
  output logic signed [POSITION_WIDTH-1:0] out_pos_z,
  output logic signed [15:0]               out_nrm_x,
  output logic signed [15:0]               out_nrm_y,
  output logic signed [15:0]               out_nrm_z,
  output logic [1:0]                       out_status,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [2:0]                       cfg_index,
  input  logic [63:0]                      cfg_data
);
  localparam int PW  = POSITION_WIDTH;
  localparam int PL  = PW + 4;
  localparam int DLY = vnt_pkg::NRM_LAT - PL;
  localparam int LAT = vnt_pkg::FRONT_LAT + vnt_pkg::NRM_LAT;
  localparam logic signed [PW-1:0] PMAX = {1'b0, {(PW-1){1'b1}}};
  localparam logic signed [PW-1:0] PMIN = {1'b1, {(PW-1){1'b0}}};

  vnt_pkg::cfg_t cfg_r;
  logic          acc;
  logic signed [PW-1:0] pos_in [3];
  logic signed [15:0]   nrm_in [3];
  logic                 f_vld, f_cmd;
  logic signed [PW+17:0] f_num [4];
  logic signed [vnt_pkg::NSUM_W-1:0] f_nsum [3];
  logic [PW-1:0]        p_pos [3];
  logic                 p_wz;
  logic                 n_vld, n_zero;
  logic [15:0]          n_nrm [3];
  logic [PW-1:0]        dl_pos_r [DLY][3];
  logic                 dl_wz_r  [DLY];

  assign busy      = ~rst_n;
  assign cfg_ready = 1'b1;
  assign acc       = start & ~busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.prow[0] <= vnt_pkg::RST_ROW_X;
      cfg_r.prow[1] <= vnt_pkg::RST_ROW_Y;
      cfg_r.prow[2] <= vnt_pkg::RST_ROW_Z;
      cfg_r.prow[3] <= vnt_pkg::RST_ROW_W;
      cfg_r.nrow[0] <= vnt_pkg::RST_NROW_X;
      cfg_r.nrow[1] <= vnt_pkg::RST_NROW_Y;
      cfg_r.nrow[2] <= vnt_pkg::RST_NROW_Z;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        vnt_pkg::REG_ROW_X:  cfg_r.prow[0] <= cfg_data;
        vnt_pkg::REG_ROW_Y:  cfg_r.prow[1] <= cfg_data;
        vnt_pkg::REG_ROW_Z:  cfg_r.prow[2] <= cfg_data;
        vnt_pkg::REG_ROW_W:  cfg_r.prow[3] <= cfg_data;
        vnt_pkg::REG_NROW_X: cfg_r.nrow[0] <= cfg_data[47:0];
        vnt_pkg::REG_NROW_Y: cfg_r.nrow[1] <= cfg_data[47:0];
        vnt_pkg::REG_NROW_Z: cfg_r.nrow[2] <= cfg_data[47:0];
        default: ;
      endcase
    end
  end

  assign pos_in[0] = in_pos_x;
  assign pos_in[1] = in_pos_y;
  assign pos_in[2] = in_pos_z;
  assign nrm_in[0] = in_nrm_x;
  assign nrm_in[1] = in_nrm_y;
  assign nrm_in[2] = in_nrm_z;

  vnt_front #(.PW(PW)) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_vld (acc),
    .in_cmd (in_command),
    .pos    (pos_in),
    .nrm    (nrm_in),
    .cfg    (cfg_r),
    .o_vld  (f_vld),
    .o_cmd  (f_cmd),
    .num    (f_num),
    .nsum   (f_nsum)
  );

  vnt_pos_div #(.PW(PW)) u_pos (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_vld (f_vld),
    .in_cmd (f_cmd),
    .num    (f_num),
    .o_pos  (p_pos),
    .o_wz   (p_wz)
  );

  vnt_nrm_unit u_nrm (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_vld (f_vld),
    .nsum   (f_nsum),
    .o_vld  (n_vld),
    .o_nrm  (n_nrm),
    .o_zero (n_zero)
  );

  // position results wait for the longer normal path
  always_ff @(posedge clk) begin
    dl_pos_r[0] <= p_pos;
    dl_wz_r[0]  <= p_wz;
    for (int s = 1; s < DLY; s++) begin
      dl_pos_r[s] <= dl_pos_r[s-1];
      dl_wz_r[s]  <= dl_wz_r[s-1];
    end
  end

  assign out_valid  = n_vld;
  assign out_pos_x  = dl_pos_r[DLY-1][0];
  assign out_pos_y  = dl_pos_r[DLY-1][1];
  assign out_pos_z  = dl_pos_r[DLY-1][2];
  assign out_nrm_x  = n_nrm[0];
  assign out_nrm_y  = n_nrm[1];
  assign out_nrm_z  = n_nrm[2];
  assign out_status = {n_zero, dl_wz_r[DLY-1]};

  `VNT_ASSERT_DLY(a_latency, acc, LAT, out_valid)
  `VNT_ASSERT_IMP(a_zero_nrm, out_valid && out_status[1], (out_nrm_x == '0 && out_nrm_y == '0 && out_nrm_z == '0))
  `VNT_ASSERT_IMP(a_wz_sat, out_valid && out_status[0], (out_pos_x == PMAX || out_pos_x == PMIN || out_pos_x == '0))

endmodule

### tb/testbench.sv
// self-checking bench for vertex_normal_transform_top: directed table then random items
// predicts with its own fixed-point model of positions and normals, or uses known rows
// depends on vnt_pkg and the vertex_normal_transform_top rtl
module testbench;

  localparam int PW = 24;
  localparam int LAT = 57;
  localparam int LIMIT = 2000000;

  typedef struct {
    logic [PW-1:0] px, py, pz;
    logic [15:0]   nx, ny, nz;
    logic [1:0]    st;
  } vtx_result_t;

  typedef struct {
    logic          cmd;
    logic [PW-1:0] px, py, pz;
    logic [15:0]   nx, ny, nz;
    logic          known;
    vtx_result_t   res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_command = 1'b0;
  logic signed [PW-1:0] in_pos_x = '0, in_pos_y = '0, in_pos_z = '0;
  logic signed [15:0] in_nrm_x = '0, in_nrm_y = '0, in_nrm_z = '0;
  logic out_valid;
  logic signed [PW-1:0] out_pos_x, out_pos_y, out_pos_z;
  logic signed [15:0] out_nrm_x, out_nrm_y, out_nrm_z;
  logic [1:0] out_status;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;

  logic [63:0] prow [4];
  logic [47:0] nrow [3];
  vtx_result_t pending_results[$];
  int errors = 0;
  int cycles = 0;

  vertex_normal_transform_top #(.POSITION_WIDTH(PW)) u_dut (.*);

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic longint lane16(logic [63:0] r, int k);
    logic signed [15:0] v;
    v = r[16*k +: 16];
    return longint'(v);
  endfunction

  function automatic longint dot3(logic [63:0] r, longint x, longint y, longint z);
    return lane16(r, 0) * x + lane16(r, 1) * y + lane16(r, 2) * z;
  endfunction

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic vtx_result_t transform_vertex(stim_row_t s);
    vtx_result_t r;
    longint x, y, z, w, num, q, pmax, pmin;
    longint pos [3];
    longint nin [3];
    longint unsigned mag [3];
    longint unsigned mx, sumsq, rt, uq;
    bit neg [3];
    longint sres;
    pmax = (64'sd1 <<< (PW - 1)) - 1;
    pmin = -pmax - 1;
    r.st = 2'b00;
    pos = '{0, 0, 0};
    if (s.cmd == 1'b0) begin
      x = longint'($signed(s.px));
      y = longint'($signed(s.py));
      z = longint'($signed(s.pz));
      w = dot3(prow[vnt_pkg::REG_ROW_W], x, y, z)
          + lane16(prow[vnt_pkg::REG_ROW_W], 3) * 65536;
      for (int i = 0; i < 3; i++) begin
        num = dot3(prow[i], x, y, z) + lane16(prow[i], 3) * 65536;
        if (w == 0) q = (num > 0) ? pmax : ((num < 0) ? pmin : 0);
        else begin
          q = (num * 4096) / w;
          if (q > pmax) q = pmax;
          if (q < pmin) q = pmin;
        end
        pos[i] = q;
      end
      if (w == 0) r.st[0] = 1'b1;
    end
    r.px = pos[0][PW-1:0];
    r.py = pos[1][PW-1:0];
    r.pz = pos[2][PW-1:0];
    nin[0] = longint'($signed(s.nx));
    nin[1] = longint'($signed(s.ny));
    nin[2] = longint'($signed(s.nz));
    mx = 0;
    for (int i = 0; i < 3; i++) begin
      sres = dot3({16'd0, nrow[i]}, nin[0], nin[1], nin[2]);
      neg[i] = sres < 0;
      mag[i] = neg[i] ? longint'(-sres) : longint'(sres);
      if (mag[i] > mx) mx = mag[i];
    end
    r.nx = '0;
    r.ny = '0;
    r.nz = '0;
    if (mx == 0) r.st[1] = 1'b1;
    else begin
      while (mx < (64'd1 << 29)) begin
        mx <<= 1;
        for (int i = 0; i < 3; i++) mag[i] <<= 1;
      end
      while (mx >= (64'd1 << 30)) begin
        mx >>= 1;
        for (int i = 0; i < 3; i++) mag[i] >>= 1;
      end
      sumsq = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
      rt = root_floor(sumsq);
      for (int i = 0; i < 3; i++) begin
        uq = ((mag[i] << 14) + (rt >> 1)) / rt;
        if (uq > 32767) uq = 32767;
        nin[i] = neg[i] ? -longint'(uq) : longint'(uq);
      end
      r.nx = nin[0][15:0];
      r.ny = nin[1][15:0];
      r.nz = nin[2][15:0];
    end
    return r;
  endfunction

  function automatic void add_expected(vtx_result_t r);
    pending_results.insert(pending_results.size(), r);
  endfunction

  always @(posedge clk) begin
    vtx_result_t e;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result pos %h %h %h", $time, out_pos_x, out_pos_y, out_pos_z);
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (e.px !== out_pos_x || e.py !== out_pos_y || e.pz !== out_pos_z) begin
          $display("%0t pos expected %h %h %h actual %h %h %h", $time,
                   e.px, e.py, e.pz, out_pos_x, out_pos_y, out_pos_z);
          errors++;
        end
        if (e.nx !== out_nrm_x || e.ny !== out_nrm_y || e.nz !== out_nrm_z) begin
          $display("%0t nrm expected %h %h %h actual %h %h %h", $time,
                   e.nx, e.ny, e.nz, out_nrm_x, out_nrm_y, out_nrm_z);
          errors++;
        end
        if (e.st !== out_status) begin
          $display("%0t status expected %b actual %b", $time, e.st, out_status);
          errors++;
        end
      end
    end
  end

  task automatic send_item(stim_row_t s);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_command <= s.cmd;
    in_pos_x <= s.px;
    in_pos_y <= s.py;
    in_pos_z <= s.pz;
    in_nrm_x <= s.nx;
    in_nrm_y <= s.ny;
    in_nrm_z <= s.nz;
    do @(posedge clk); while (busy);
    add_expected(s.known ? s.res : transform_vertex(s));
  endtask

  task automatic drain;
    int guard;
    guard = 0;
    start <= 1'b0;
    while (pending_results.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (LAT + 4) @(posedge clk);
  endtask

  task automatic write_reg(vnt_pkg::reg_idx_t idx, logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx <= vnt_pkg::REG_ROW_W) prow[idx] = val;
    else nrow[idx - vnt_pkg::REG_NROW_X] = val[47:0];
    @(posedge clk);
  endtask

  function automatic stim_row_t rand_item();
    stim_row_t s;
    int mode;
    mode = $urandom_range(0, 9);
    s.cmd = $urandom_range(0, 3) == 0;
    s.px = $urandom;
    s.py = $urandom;
    s.pz = $urandom;
    if (mode < 4) begin
      s.px = $signed(s.px) >>> $urandom_range(0, 16);
      s.py = $signed(s.py) >>> $urandom_range(0, 16);
      s.pz = $signed(s.pz) >>> $urandom_range(0, 16);
    end
    s.nx = $urandom;
    s.ny = $urandom;
    s.nz = $urandom;
    if (mode == 9) begin
      s.nx = '0;
      s.ny = '0;
      s.nz = '0;
    end
    s.known = 1'b0;
    return s;
  endfunction

  function automatic logic [63:0] rand_row(bit sane);
    logic [63:0] v;
    v = {$urandom, $urandom};
    if (sane) begin
      for (int k = 0; k < 4; k++)
        v[16*k +: 16] = $signed(v[16*k +: 16]) >>> $urandom_range(1, 8);
    end
    return v;
  endfunction

  initial begin
    stim_row_t dir [7];
    stim_row_t s;
    vtx_result_t k;
    vnt_pkg::reg_idx_t ri;
    prow[0] = vnt_pkg::RST_ROW_X;
    prow[1] = vnt_pkg::RST_ROW_Y;
    prow[2] = vnt_pkg::RST_ROW_Z;
    prow[3] = vnt_pkg::RST_ROW_W;
    nrow[0] = vnt_pkg::RST_NROW_X;
    nrow[1] = vnt_pkg::RST_NROW_Y;
    nrow[2] = vnt_pkg::RST_NROW_Z;

    // identity after reset: unit normals and face items read off directly
    k = '{px: 24'h001000, py: 24'h002000, pz: 24'hFFF000,
          nx: 16'h4000, ny: 16'h0000, nz: 16'h0000, st: 2'b00};
    dir[0] = '{1'b0, 24'h001000, 24'h002000, 24'hFFF000,
               16'h4000, 16'h0000, 16'h0000, 1'b1, k};
    k = '{px: 24'h0, py: 24'h0, pz: 24'h0, nx: 16'h0, ny: 16'hC000, nz: 16'h0, st: 2'b00};
    dir[1] = '{1'b1, 24'h7FFFFF, 24'h800000, 24'h123456,
               16'h0000, 16'h8000, 16'h0000, 1'b1, k};
    k = '{px: 24'h0, py: 24'h0, pz: 24'h0, nx: 16'h0, ny: 16'h0, nz: 16'h0, st: 2'b10};
    dir[2] = '{1'b1, 24'h0, 24'h0, 24'h0, 16'h0, 16'h0, 16'h0, 1'b1, k};
    dir[3] = '{1'b0, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF,
               16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0, k};
    dir[4] = '{1'b0, 24'h800000, 24'h800000, 24'h800000,
               16'h8000, 16'h8000, 16'h8000, 1'b0, k};
    dir[5] = '{1'b0, 24'h000001, 24'hFFFFFF, 24'h0, 16'h0001, 16'hFFFF, 16'h0, 1'b0, k};
    dir[6] = '{1'b0, 24'h0, 24'h0, 24'h0, 16'h0, 16'h0, 16'h0, 1'b0, k};

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir[i]) send_item(dir[i]);
    drain();

    // w row zero: saturated or zero positions and status bit0
    write_reg(vnt_pkg::REG_ROW_W, 64'd0);
    for (int i = 0; i < 6; i++) begin
      s = rand_item();
      s.cmd = 1'b0;
      if (i == 0) begin
        s.px = '0;
        s.py = '0;
        s.pz = '0;
      end
      send_item(s);
    end
    drain();

    // extremes of every register
    for (int r = 0; r < 7; r++) begin
      ri = vnt_pkg::reg_idx_t'(r);
      write_reg(ri, {64{1'b1}});
    end
    for (int i = 0; i < 12; i++) send_item(rand_item());
    drain();
    for (int r = 0; r < 7; r++) begin
      ri = vnt_pkg::reg_idx_t'(r);
      write_reg(ri, (r < 4) ? 64'h8000_8000_8000_8000 : 64'h7FFF_7FFF_7FFF_7FFF);
    end
    for (int i = 0; i < 12; i++) send_item(rand_item());
    drain();

    // random phases with a fresh matrix each time
    for (int ph = 0; ph < 10; ph++) begin
      for (int r = 0; r < 7; r++) begin
        ri = vnt_pkg::reg_idx_t'(r);
        write_reg(ri, rand_row(ph % 3 != 0));
      end
      if (ph == 4) write_reg(vnt_pkg::REG_NROW_Y, 64'd0);
      for (int i = 0; i < 180; i++) begin
        if (ph == 5 && i < 60) begin
          s = rand_item();
          start <= 1'b1;
          in_command <= s.cmd;
          in_pos_x <= s.px;
          in_pos_y <= s.py;
          in_pos_z <= s.pz;
          in_nrm_x <= s.nx;
          in_nrm_y <= s.ny;
          in_nrm_z <= s.nz;
          do @(posedge clk); while (busy);
          add_expected(transform_vertex(s));
        end else begin
          send_item(rand_item());
        end
        if (i == 90) drain();
      end
      drain();
    end

    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

### sim.f
+incdir+design
design/vnt_pkg.sv
design/vnt_front.sv
design/vnt_pos_div.sv
design/vnt_nrm_unit.sv
design/vertex_normal_transform_top.sv
tb/testbench.sv
